// ===== hdl/qoie_pkg.sv =====
`timescale 1ns / 1ps

package qoie_pkg;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [7:0] OP_DIFF = 8'h40;
    localparam logic [7:0] OP_LUMA = 8'h80;
    localparam logic [7:0] OP_RUN  = 8'hC0;
    localparam logic [7:0] OP_RGB  = 8'hFE;
    localparam logic [7:0] OP_RGBA = 8'hFF;

    localparam logic [5:0]  RUN_MAX    = 6'd62;
    localparam logic [31:0] PREV_RESET = 32'h0000_00FF;

    typedef struct packed {
        logic            hdr;
        logic            run_en;
        logic [5:0]      run_val;
        logic [2:0]      code_len;
        logic [4:0][7:0] code;
        logic            end_en;
    } qoie_token_t;

    typedef struct packed {
        logic        en;
        logic        clear;
        logic [5:0]  slot;
        logic [31:0] pixel;
    } qoie_tbl_wr_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] pixel;
    } qoie_tbl_rd_t;

    function automatic logic [5:0] slot_hash(input logic [31:0] px);
        logic [11:0] sum;
        sum = 12'(px[31:24]) * 12'd3 + 12'(px[23:16]) * 12'd5
            + 12'(px[15:8]) * 12'd7 + 12'(px[7:0]) * 12'd11;
        return sum[5:0];
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] w,
                                            input logic [15:0] h);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h71;
            4'd1:    b = 8'h6F;
            4'd2:    b = 8'h69;
            4'd3:    b = 8'h66;
            4'd6:    b = w[15:8];
            4'd7:    b = w[7:0];
            4'd10:   b = h[15:8];
            4'd11:   b = h[7:0];
            4'd12:   b = 8'h04;
            4'd13:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/qoie_table.sv =====
`timescale 1ns / 1ps

module qoie_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [5:0]            rd_slot,
    input  qoie_pkg::qoie_tbl_wr_t wr,
    output qoie_pkg::qoie_tbl_rd_t rd
);

    logic [31:0] entry_mem [64];
    logic [31:0] rd_data_reg;
    logic [31:0] fwd_data_reg;
    logic        fwd_reg;
    logic        rd_valid_reg;
    logic [63:0] valid_reg;
    logic        same_slot;

    assign same_slot = wr.en && (wr.slot == rd_slot);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_mem[wr.slot] <= wr.pixel;
        end
        if (rd_en) begin
            rd_data_reg  <= entry_mem[rd_slot];
            fwd_data_reg <= wr.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            fwd_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.clear) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.slot] <= 1'b1;
            end
            if (rd_en) begin
                fwd_reg <= same_slot;
                if (wr.clear) begin
                    rd_valid_reg <= 1'b0;
                end else begin
                    rd_valid_reg <= same_slot || valid_reg[rd_slot];
                end
            end
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.pixel = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== hdl/qoie_code.sv =====
`timescale 1ns / 1ps

module qoie_code (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            in_pixel,
    input  logic                   in_last,
    output logic                   rd_en,
    output logic [5:0]             rd_slot,
    output qoie_pkg::qoie_tbl_wr_t wr,
    input  qoie_pkg::qoie_tbl_rd_t rd,
    input  logic                   em_idle,
    output logic                   fire,
    output logic                   tok_valid,
    output qoie_pkg::qoie_token_t  tok
);

    logic [31:0] pix_reg;
    logic        last_reg;
    logic [5:0]  slot_reg;
    logic        pvalid_reg;
    logic [31:0] prev_reg;
    logic [5:0]  run_reg;
    logic        hdr_reg;

    logic        accept;
    logic        rep;
    logic        hit;
    logic        full;
    logic [5:0]  run_inc;
    logic signed [7:0] vr, vg, vb, vgr, vgb;
    logic [7:0]  br, bg, bb, blg, bgr, bgb;
    logic        small_diff;
    logic        luma_fit;

    assign fire     = pvalid_reg && em_idle;
    assign in_ready = !pvalid_reg || fire;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_slot  = qoie_pkg::slot_hash(in_pixel);

    assign rep     = pix_reg == prev_reg;
    assign hit     = rd.valid ? (rd.pixel == pix_reg) : (pix_reg == '0);
    assign run_inc = run_reg + 6'd1;
    assign full    = run_inc == qoie_pkg::RUN_MAX;

    assign vr  = $signed(pix_reg[31:24] - prev_reg[31:24]);
    assign vg  = $signed(pix_reg[23:16] - prev_reg[23:16]);
    assign vb  = $signed(pix_reg[15:8] - prev_reg[15:8]);
    assign vgr = vr - vg;
    assign vgb = vb - vg;

    assign br  = vr + 8'sd2;
    assign bg  = vg + 8'sd2;
    assign bb  = vb + 8'sd2;
    assign blg = vg + 8'sd32;
    assign bgr = vgr + 8'sd8;
    assign bgb = vgb + 8'sd8;

    assign small_diff = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
                     && (vb >= -8'sd2) && (vb <= 8'sd1);
    assign luma_fit   = (vg >= -8'sd32) && (vg <= 8'sd31) && (vgr >= -8'sd8)
                     && (vgr <= 8'sd7) && (vgb >= -8'sd8) && (vgb <= 8'sd7);

    always_comb begin
        tok        = '0;
        tok.hdr    = hdr_reg;
        tok.end_en = last_reg;
        if (rep) begin
            tok.run_en  = full || last_reg;
            tok.run_val = run_reg;
        end else begin
            tok.run_en  = run_reg != 6'd0;
            tok.run_val = run_reg - 6'd1;
            if (hit) begin
                tok.code_len = 3'd1;
                tok.code[0]  = {2'b00, slot_reg};
            end else if (pix_reg[7:0] == prev_reg[7:0]) begin
                if (small_diff) begin
                    tok.code_len = 3'd1;
                    tok.code[0]  = qoie_pkg::OP_DIFF | {2'b00, br[1:0], bg[1:0], bb[1:0]};
                end else if (luma_fit) begin
                    tok.code_len = 3'd2;
                    tok.code[0]  = qoie_pkg::OP_LUMA | {2'b00, blg[5:0]};
                    tok.code[1]  = {bgr[3:0], bgb[3:0]};
                end else begin
                    tok.code_len = 3'd4;
                    tok.code[0]  = qoie_pkg::OP_RGB;
                    tok.code[1]  = pix_reg[31:24];
                    tok.code[2]  = pix_reg[23:16];
                    tok.code[3]  = pix_reg[15:8];
                end
            end else begin
                tok.code_len = 3'd5;
                tok.code[0]  = qoie_pkg::OP_RGBA;
                tok.code[1]  = pix_reg[31:24];
                tok.code[2]  = pix_reg[23:16];
                tok.code[3]  = pix_reg[15:8];
                tok.code[4]  = pix_reg[7:0];
            end
        end
    end

    assign tok_valid = fire && (tok.hdr || tok.run_en || (tok.code_len != 3'd0) || tok.end_en);

    assign wr.en    = fire && !rep && !hit;
    assign wr.clear = fire && last_reg;
    assign wr.slot  = slot_reg;
    assign wr.pixel = pix_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg  <= in_pixel;
            last_reg <= in_last;
            slot_reg <= rd_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
            prev_reg   <= qoie_pkg::PREV_RESET;
            run_reg    <= '0;
            hdr_reg    <= 1'b1;
        end else begin
            if (accept) begin
                pvalid_reg <= 1'b1;
            end else if (fire) begin
                pvalid_reg <= 1'b0;
            end
            if (fire) begin
                if (last_reg) begin
                    prev_reg <= qoie_pkg::PREV_RESET;
                    run_reg  <= '0;
                    hdr_reg  <= 1'b1;
                end else begin
                    hdr_reg <= 1'b0;
                    if (rep) begin
                        run_reg <= full ? 6'd0 : run_inc;
                    end else begin
                        run_reg  <= '0;
                        prev_reg <= pix_reg;
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/qoie_emit.sv =====
`timescale 1ns / 1ps

module qoie_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [15:0]           image_width,
    input  logic [15:0]           image_height,
    input  logic                  load,
    input  qoie_pkg::qoie_token_t tok,
    output logic                  idle,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte
    output logic                  m_tlast
);

    typedef enum logic [4:0] {
        EM_IDLE = 5'b00001,
        EM_HDR  = 5'b00010,
        EM_RUN  = 5'b00100,
        EM_CODE = 5'b01000,
        EM_END  = 5'b10000
    } em_state_t;

    em_state_t             state_reg;
    logic [3:0]            cnt_reg;
    qoie_pkg::qoie_token_t tok_reg;

    em_state_t after_code, after_run, after_hdr, first_state, follow;
    logic      done;

    assign after_code = tok_reg.end_en ? EM_END : EM_IDLE;
    assign after_run  = (tok_reg.code_len != 3'd0) ? EM_CODE : after_code;
    assign after_hdr  = tok_reg.run_en ? EM_RUN : after_run;

    always_comb begin
        priority if (tok.hdr) begin
            first_state = EM_HDR;
        end else if (tok.run_en) begin
            first_state = EM_RUN;
        end else if (tok.code_len != 3'd0) begin
            first_state = EM_CODE;
        end else begin
            first_state = EM_END;
        end
    end

    always_comb begin
        unique case (state_reg)
            EM_HDR: begin
                done    = cnt_reg == 4'd13;
                follow  = after_hdr;
                m_tdata = qoie_pkg::hdr_byte(cnt_reg, image_width, image_height);
            end
            EM_RUN: begin
                done    = 1'b1;
                follow  = after_run;
                m_tdata = qoie_pkg::OP_RUN | {2'b00, tok_reg.run_val};
            end
            EM_CODE: begin
                done    = cnt_reg == {1'b0, tok_reg.code_len - 3'd1};
                follow  = after_code;
                m_tdata = tok_reg.code[cnt_reg[2:0]];
            end
            EM_END: begin
                done    = cnt_reg == 4'd7;
                follow  = EM_IDLE;
                m_tdata = (cnt_reg == 4'd7) ? 8'h01 : 8'h00;
            end
            default: begin
                done    = 1'b0;
                follow  = EM_IDLE;
                m_tdata = 8'h00;
            end
        endcase
    end

    assign idle     = state_reg == EM_IDLE;
    assign m_tvalid = !idle;
    assign m_tlast  = done && (follow == EM_IDLE);

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            cnt_reg   <= '0;
        end else if (load) begin
            state_reg <= first_state;
            cnt_reg   <= '0;
        end else if (m_tvalid && m_tready) begin
            if (done) begin
                state_reg <= follow;
                cnt_reg   <= '0;
            end else begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

endmodule

// ===== hdl/qoi_image_encoder.sv =====
`timescale 1ns / 1ps
// QOI image encoder. Pixels enter on the s_ stream, one RGBA word per
// transfer, with s_tlast on the final pixel of the image. Encoded bytes
// leave on the m_ stream, one byte per word; m_tlast marks the final byte
// that a pixel causes. The first pixel of an image brings the 14-byte
// header, the last pixel the run flush and the 8-byte end marker, after
// which a new image starts. The user must write width and height on the
// cfg_ port only while the block is idle; the block does not enforce
// this. Both are kept across images. A pixel is accepted into a one-entry
// stage that also reads the 64-entry color table; its token is loaded
// into the byte sequencer's registered state once the sequencer is idle,
// and the first byte is presented from there. The sequencer then sends
// one byte per cycle while the receiver is ready, and a pixel that only
// extends a run causes no byte of its own. While the receiver stalls, the
// sequencer holds its byte and one more pixel is still accepted. Reset
// clears the table through its valid bits, so pixels are taken at once.
module qoi_image_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // red, green, blue, alpha
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;

    logic                   rd_en;
    logic [5:0]             rd_slot;
    qoie_pkg::qoie_tbl_wr_t tbl_wr;
    qoie_pkg::qoie_tbl_rd_t tbl_rd;
    logic                   em_idle;
    logic                   code_fire;
    logic                   tok_valid;
    qoie_pkg::qoie_token_t  tok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                qoie_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                qoie_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    qoie_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .wr      (tbl_wr),
        .rd      (tbl_rd)
    );

    qoie_code u_code (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
        .in_last   (s_tlast),
        .rd_en     (rd_en),
        .rd_slot   (rd_slot),
        .wr        (tbl_wr),
        .rd        (tbl_rd),
        .em_idle   (em_idle),
        .fire      (code_fire),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    qoie_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .load         (tok_valid),
        .tok          (tok),
        .idle         (em_idle),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    a_load_starts_output: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_valid |=> m_tvalid)
        else $error("token loaded but no byte presented");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("sequencer busy after final byte of a pixel");

    a_table_write_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en || tbl_wr.clear |-> code_fire)
        else $error("color table changed without a pixel leaving the stage");

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        code_fire |-> !m_tvalid)
        else $error("pixel stage fired while sequencer busy");

endmodule
